// File: hw/rtl/priority_lru_voice_allocator_core_macros.svh
// Assertion macros used by the voice allocator datapath.
// No dependencies; each macro compiles to nothing when SYNTH is defined.
`ifndef PRIORITY_LRU_VOICE_ALLOCATOR_CORE_MACROS_SVH
`define PRIORITY_LRU_VOICE_ALLOCATOR_CORE_MACROS_SVH

`ifndef SYNTH
// Condition that must hold at every clock edge outside reset.
`define PLVA_ASSERT(name, clk, rst_n, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Condition that must hold in the cycle after a trigger.
`define PLVA_ASSERT_NEXT(name, clk, rst_n, trig, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);
`else
`define PLVA_ASSERT(name, clk, rst_n, cond, msg)
`define PLVA_ASSERT_NEXT(name, clk, rst_n, trig, cond, msg)
`endif

`endif

// File: hw/rtl/plva_pkg.sv
// Shared types and constants of the priority LRU voice allocator.
// No dependencies; used by the controller, the datapath and the top level.
package plva_pkg;

    // Default number of voice slots.
    localparam int NUM_VOICES_DEF = 16;

    // Field widths of the request and result beats.
    localparam int HANDLE_W = 16;
    localparam int BUFFER_W = 8;
    localparam int SLOT_W   = 4;

    // Request operation codes.
    typedef enum logic {
        OP_ALLOC   = 1'b0,
        OP_RELEASE = 1'b1
    } t_op;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMPACT,
        ST_TAIL,
        ST_RESULT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the request beat, clear the step counter
        logic rot_full;  // rotate the whole usage order by one
        logic rot_sub;   // rotate all entries but the head by one
        logic cnt_inc;   // advance the step counter
        logic capture;   // take the head slot: read owner, update slot state
        logic out_load;  // write the result register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic skip;        // release with no usable slot id
        logic is_release;  // current request is a release
        logic head_match;  // head of the usage order is the wanted slot
        logic cnt_last;    // step counter reached NUM_VOICES-1
        logic out_free;    // result register can take a new beat
    } t_status;

endpackage

// File: hw/rtl/plva_ctrl.sv
// Controller state machine of the voice allocator.
// Depends on plva_pkg; drives the datapath through t_cmd and reads t_status.
module plva_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  plva_pkg::t_status i_status,
    output plva_pkg::t_cmd    o_cmd
);
    import plva_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (i_status.skip) begin
                    n_state = ST_RESULT;
                end else if (i_status.head_match) begin
                    n_state = ST_COMPACT;
                end else if (i_status.cnt_last) begin
                    n_state = ST_RESULT;
                end
            end
            ST_COMPACT: begin
                if (i_status.cnt_last) begin
                    n_state = i_status.is_release ? ST_RESULT : ST_TAIL;
                end
            end
            ST_TAIL: begin
                n_state = ST_RESULT;
            end
            ST_RESULT: begin
                if (i_status.out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Command outputs.
    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready  = 1'b1;
                o_cmd.load = i_valid;
            end
            ST_SCAN: begin
                if (!i_status.skip) begin
                    if (i_status.head_match) begin
                        o_cmd.capture = 1'b1;
                    end else begin
                        o_cmd.rot_full = 1'b1;
                        o_cmd.cnt_inc  = 1'b1;
                    end
                end
            end
            ST_COMPACT: begin
                if (!i_status.cnt_last) begin
                    o_cmd.rot_sub = 1'b1;
                    o_cmd.cnt_inc = 1'b1;
                end
            end
            ST_TAIL: begin
                o_cmd.rot_full = 1'b1;
            end
            ST_RESULT: begin
                o_cmd.out_load = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// File: hw/rtl/plva_datapath.sv
// Datapath of the voice allocator: usage order, slot state, owner memory
// and result register. Depends on plva_pkg and the assertion macro header.
`include "priority_lru_voice_allocator_core_macros.svh"

module plva_datapath #(
    parameter int NUM_VOICES = plva_pkg::NUM_VOICES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  plva_pkg::t_cmd                i_cmd,
    output plva_pkg::t_status             o_status,
    input  logic                          i_operation,
    input  logic [plva_pkg::HANDLE_W-1:0] i_owner_handle,
    input  logic                          i_high_priority,
    input  logic [plva_pkg::BUFFER_W-1:0] i_buffer_id,
    input  logic                          i_release_slot_valid,
    input  logic [plva_pkg::SLOT_W-1:0]   i_release_slot,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic                          o_granted,
    output logic [plva_pkg::SLOT_W-1:0]   o_slot_id,
    output logic                          o_stop_voice,
    output logic [plva_pkg::HANDLE_W-1:0] o_evicted_handle,
    output logic [plva_pkg::BUFFER_W-1:0] o_bind_buffer
);
    import plva_pkg::*;

    localparam int ID_W = $clog2(NUM_VOICES);

    // Request registers.
    t_op                 r_op;
    logic [HANDLE_W-1:0] r_handle;
    logic                r_prio;
    logic [BUFFER_W-1:0] r_buf;
    logic                r_rel_valid;
    logic [SLOT_W-1:0]   r_rel_slot;

    // Usage order, oldest at index 0, and per-slot state.
    logic [ID_W-1:0]       r_order [NUM_VOICES];
    logic [ID_W-1:0]       n_order [NUM_VOICES];
    logic [NUM_VOICES-1:0] r_occupied;
    logic [NUM_VOICES-1:0] r_locked;
    logic [HANDLE_W-1:0]   r_owner_mem [NUM_VOICES];

    // Step counter and captured facts about the chosen slot.
    logic [ID_W-1:0]     r_cnt;
    logic                r_hit;
    logic [ID_W-1:0]     r_found_id;
    logic                r_stop;
    logic [HANDLE_W-1:0] r_owner_rd;

    // Result register.
    logic                r_o_valid;
    logic                r_o_granted;
    logic [SLOT_W-1:0]   r_o_slot;
    logic                r_o_stop;
    logic [HANDLE_W-1:0] r_o_evicted;
    logic [BUFFER_W-1:0] r_o_bind;

    logic [ID_W-1:0]        w_head;
    logic [ID_W+SLOT_W-1:0] w_head_ext;
    logic [ID_W+SLOT_W-1:0] w_rel_ext;
    logic [ID_W+SLOT_W-1:0] w_found_ext;
    logic                   w_rel_ok;
    logic                   w_granted;
    logic                   w_stop;

    assign w_head      = r_order[0];
    assign w_head_ext  = {{SLOT_W{1'b0}}, w_head};
    assign w_rel_ext   = {{ID_W{1'b0}}, r_rel_slot};
    assign w_found_ext = {{SLOT_W{1'b0}}, r_found_id};
    assign w_rel_ok    = r_rel_valid && (32'(r_rel_slot) < NUM_VOICES);

    // Status toward the controller.
    always_comb begin
        o_status.skip       = (r_op == OP_RELEASE) && !w_rel_ok;
        o_status.is_release = (r_op == OP_RELEASE);
        if (r_op == OP_ALLOC) begin
            o_status.head_match = !(r_occupied[w_head] && r_locked[w_head]);
        end else begin
            o_status.head_match = (w_head_ext == w_rel_ext);
        end
        o_status.cnt_last = (r_cnt == ID_W'(NUM_VOICES - 1));
        o_status.out_free = !r_o_valid || i_out_ready;
    end

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op        <= t_op'(i_operation);
            r_handle    <= i_owner_handle;
            r_prio      <= i_high_priority;
            r_buf       <= i_buffer_id;
            r_rel_valid <= i_release_slot_valid;
            r_rel_slot  <= i_release_slot;
        end
    end

    // Rotation of the usage order: whole list, or all but the head.
    always_comb begin
        for (int i = 0; i < NUM_VOICES; i++) begin
            n_order[i] = r_order[i];
        end
        if (i_cmd.rot_full) begin
            for (int i = 0; i < NUM_VOICES - 1; i++) begin
                n_order[i] = r_order[i+1];
            end
            n_order[NUM_VOICES-1] = r_order[0];
        end else if (i_cmd.rot_sub) begin
            for (int i = 1; i < NUM_VOICES - 1; i++) begin
                n_order[i] = r_order[i+1];
            end
            n_order[NUM_VOICES-1] = r_order[1];
        end
    end

    // Usage order and slot flags; reset puts ids in ascending order.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_VOICES; i++) begin
                r_order[i] <= ID_W'(i);
            end
            r_occupied <= '0;
            r_locked   <= '0;
        end else begin
            for (int i = 0; i < NUM_VOICES; i++) begin
                r_order[i] <= n_order[i];
            end
            if (i_cmd.capture) begin
                if (r_op == OP_ALLOC) begin
                    r_occupied[w_head] <= 1'b1;
                    r_locked[w_head]   <= r_prio;
                end else begin
                    r_occupied[w_head] <= 1'b0;
                    r_locked[w_head]   <= 1'b0;
                end
            end
        end
    end

    // Owner memory; an entry is only meaningful while its slot is occupied.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_owner_rd <= r_owner_mem[w_head];
            if (r_op == OP_ALLOC) begin
                r_owner_mem[w_head] <= r_handle;
            end
        end
    end

    // Step counter and chosen-slot capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cnt <= '0;
            r_hit <= 1'b0;
        end else begin
            if (i_cmd.cnt_inc) r_cnt <= r_cnt + 1'b1;
            if (i_cmd.capture) begin
                r_hit      <= 1'b1;
                r_found_id <= w_head;
                r_stop     <= r_occupied[w_head];
            end
        end
    end

    // Result beat.
    assign w_granted = r_hit && (r_op == OP_ALLOC);
    assign w_stop    = r_hit && r_stop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_granted <= w_granted;
            r_o_slot    <= r_hit ? w_found_ext[SLOT_W-1:0] : '0;
            r_o_stop    <= w_stop;
            r_o_evicted <= w_stop ? r_owner_rd : '0;
            r_o_bind    <= w_granted ? r_buf : '0;
        end
    end

    assign o_out_valid      = r_o_valid;
    assign o_granted        = r_o_granted;
    assign o_slot_id        = r_o_slot;
    assign o_stop_voice     = r_o_stop;
    assign o_evicted_handle = r_o_evicted;
    assign o_bind_buffer    = r_o_bind;

    // A slot can only be locked while it has an owner.
    `PLVA_ASSERT(a_lock_needs_owner, i_clk, i_rst_n, (r_locked & ~r_occupied) == '0, "locked slot without owner")
    // A granted slot is marked occupied right after the capture.
    `PLVA_ASSERT_NEXT(a_alloc_marks, i_clk, i_rst_n, i_cmd.capture && (r_op == OP_ALLOC), r_occupied[r_found_id], "allocated slot not occupied")
    // Oldest and newest entries of the usage order are never the same id.
    `PLVA_ASSERT(a_order_ends, i_clk, i_rst_n, r_order[0] != r_order[NUM_VOICES-1], "usage order repeats an id")
    // A bound buffer is only reported with a grant.
    `PLVA_ASSERT(a_bind_with_grant, i_clk, i_rst_n, !r_o_valid || (r_o_bind == '0) || r_o_granted, "buffer bound without grant")

endmodule

// File: hw/rtl/priority_lru_voice_allocator_core.sv
// Priority LRU voice allocator. An allocate scans the usage order from the oldest end, closes
// the gap and moves the chosen slot to the newest end; a failed allocate only scans; a valid
// release moves its slot to the oldest end; a release without a usable slot goes to the result.
// One position of the usage order is walked or rotated per cycle. A new beat is taken in the
// cycle after a result is loaded. Reset is synchronous and active low; there is no clearing pass.
// Top level: joins plva_ctrl and plva_datapath; depends on plva_pkg.
module priority_lru_voice_allocator_core #(
    parameter int NUM_VOICES = plva_pkg::NUM_VOICES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_operation,
    input  logic [plva_pkg::HANDLE_W-1:0] i_owner_handle,
    input  logic                          i_high_priority,
    input  logic [plva_pkg::BUFFER_W-1:0] i_buffer_id,
    input  logic                          i_release_slot_valid,
    input  logic [plva_pkg::SLOT_W-1:0]   i_release_slot,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_granted,
    output logic [plva_pkg::SLOT_W-1:0]   o_slot_id,
    output logic                          o_stop_voice,
    output logic [plva_pkg::HANDLE_W-1:0] o_evicted_handle,
    output logic [plva_pkg::BUFFER_W-1:0] o_bind_buffer
);
    import plva_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    // Sequencer for the walk, rotation and result handoff.
    plva_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    // Usage order, slot state and result register.
    plva_datapath #(
        .NUM_VOICES (NUM_VOICES)
    ) u_datapath (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (w_cmd),
        .o_status             (w_status),
        .i_operation          (i_operation),
        .i_owner_handle       (i_owner_handle),
        .i_high_priority      (i_high_priority),
        .i_buffer_id          (i_buffer_id),
        .i_release_slot_valid (i_release_slot_valid),
        .i_release_slot       (i_release_slot),
        .i_out_ready          (i_ready),
        .o_out_valid          (o_valid),
        .o_granted            (o_granted),
        .o_slot_id            (o_slot_id),
        .o_stop_voice         (o_stop_voice),
        .o_evicted_handle     (o_evicted_handle),
        .o_bind_buffer        (o_bind_buffer)
    );

endmodule

// File: verif/priority_lru_voice_allocator_core_tb.sv
// Self-checking testbench for priority_lru_voice_allocator_core.
// Depends on plva_pkg and the core. Directed cases run first, then random traffic
// checked against an in-bench slot-order model.
module priority_lru_voice_allocator_core_tb;
    import plva_pkg::*;

    localparam int NV           = NUM_VOICES_DEF;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 3 * NV;
    localparam int PHASE_ITEMS  = 360;

    // One request beat and one result beat, field by field.
    typedef struct packed {
        t_op                 op;
        logic [HANDLE_W-1:0] handle;
        logic                high_prio;
        logic [BUFFER_W-1:0] buffer;
        logic                rel_valid;
        logic [SLOT_W-1:0]   rel_slot;
    } t_voice_request;

    typedef struct packed {
        logic                granted;
        logic [SLOT_W-1:0]   slot_id;
        logic                stop_voice;
        logic [HANDLE_W-1:0] evicted;
        logic [BUFFER_W-1:0] bind_buffer;
    } t_voice_result;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic                i_operation;
    logic [HANDLE_W-1:0] i_owner_handle;
    logic                i_high_priority;
    logic [BUFFER_W-1:0] i_buffer_id;
    logic                i_release_slot_valid;
    logic [SLOT_W-1:0]   i_release_slot;
    logic                o_valid;
    logic                i_ready;
    logic                o_granted;
    logic [SLOT_W-1:0]   o_slot_id;
    logic                o_stop_voice;
    logic [HANDLE_W-1:0] o_evicted_handle;
    logic [BUFFER_W-1:0] o_bind_buffer;

    // Slot model: usage order oldest first, plus per-slot occupancy, lock and owner.
    int unsigned         lru_order [NV];
    logic                slot_busy [NV];
    logic                slot_pinned [NV];
    logic [HANDLE_W-1:0] slot_holder [NV];

    t_voice_result pending_voice_results[$];
    t_voice_result next_expected;
    int            mismatch_count;
    int            send_idle_pct;
    int            recv_idle_pct;
    int            stall_cycles;

    priority_lru_voice_allocator_core #(
        .NUM_VOICES(NV)
    ) dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_operation         (i_operation),
        .i_owner_handle      (i_owner_handle),
        .i_high_priority     (i_high_priority),
        .i_buffer_id         (i_buffer_id),
        .i_release_slot_valid(i_release_slot_valid),
        .i_release_slot      (i_release_slot),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_granted           (o_granted),
        .o_slot_id           (o_slot_id),
        .o_stop_voice        (o_stop_voice),
        .o_evicted_handle    (o_evicted_handle),
        .o_bind_buffer       (o_bind_buffer)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Put the slot model into its post-reset state.
    task automatic reset_voice_model();
        int p;
        for (p = 0; p < NV; p++) begin
            lru_order[p]   = p;
            slot_busy[p]   = 1'b0;
            slot_pinned[p] = 1'b0;
            slot_holder[p] = '0;
        end
    endtask

    // Apply one request to the slot model and return the result it should produce.
    function automatic t_voice_result predict_voice_result(input t_voice_request req);
        t_voice_result res;
        int            hit;
        int            p;
        int unsigned   id;
        res = '0;
        hit = -1;
        if (req.op == OP_ALLOC) begin
            // Walk from the oldest end, skipping slots held by a locked owner.
            for (p = 0; p < NV; p++) begin
                if (hit < 0 && !(slot_busy[lru_order[p]] && slot_pinned[lru_order[p]])) begin
                    hit = p;
                end
            end
            if (hit >= 0) begin
                id = lru_order[hit];
                if (slot_busy[id]) begin
                    res.stop_voice = 1'b1;
                    res.evicted    = slot_holder[id];
                end
                slot_busy[id]   = 1'b1;
                slot_pinned[id] = req.high_prio;
                slot_holder[id] = req.handle;
                for (p = hit; p < NV - 1; p++) begin
                    lru_order[p] = lru_order[p + 1];
                end
                lru_order[NV - 1] = id;
                res.granted     = 1'b1;
                res.slot_id     = id[SLOT_W-1:0];
                res.bind_buffer = req.buffer;
            end
        end else if (req.rel_valid && req.rel_slot < NV) begin
            // A release stops any owner and moves the slot to the oldest end.
            id = req.rel_slot;
            if (slot_busy[id]) begin
                res.stop_voice = 1'b1;
                res.evicted    = slot_holder[id];
            end
            slot_busy[id]   = 1'b0;
            slot_pinned[id] = 1'b0;
            slot_holder[id] = '0;
            for (p = 0; p < NV; p++) begin
                if (hit < 0 && lru_order[p] == id) begin
                    hit = p;
                end
            end
            for (p = hit; p > 0; p--) begin
                lru_order[p] = lru_order[p - 1];
            end
            lru_order[0] = id;
            res.slot_id  = id[SLOT_W-1:0];
        end
        return res;
    endfunction

    function automatic t_voice_request make_request(input t_op op,
                                                    input logic [HANDLE_W-1:0] handle,
                                                    input logic high_prio,
                                                    input logic [BUFFER_W-1:0] buffer,
                                                    input logic rel_valid,
                                                    input logic [SLOT_W-1:0] rel_slot);
        t_voice_request req;
        req.op        = op;
        req.handle    = handle;
        req.high_prio = high_prio;
        req.buffer    = buffer;
        req.rel_valid = rel_valid;
        req.rel_slot  = rel_slot;
        return req;
    endfunction

    // Drive one request beat at the falling edge and hold it until accepted.
    task automatic send_voice_request(input t_voice_request req);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid              <= 1'b1;
        i_operation          <= req.op;
        i_owner_handle       <= req.handle;
        i_high_priority      <= req.high_prio;
        i_buffer_id          <= req.buffer;
        i_release_slot_valid <= req.rel_valid;
        i_release_slot       <= req.rel_slot;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        pending_voice_results.push_back(predict_voice_result(req));
    endtask

    // Receiver side: ready drops at random according to the current phase.
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic check_field(input string name, input int unsigned expected,
                               input int unsigned actual);
        if (expected != actual) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, expected, actual);
            mismatch_count++;
        end
    endtask

    // Compare every result beat with the oldest pending prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_voice_results.size() == 0) begin
                $display("%0t: result beat with nothing pending, expected none, got slot %0d",
                         $time, o_slot_id);
                mismatch_count++;
            end else begin
                next_expected = pending_voice_results.pop_front();
                check_field("granted", next_expected.granted, o_granted);
                check_field("slot_id", next_expected.slot_id, o_slot_id);
                check_field("stop_voice", next_expected.stop_voice, o_stop_voice);
                check_field("evicted_handle", next_expected.evicted, o_evicted_handle);
                check_field("bind_buffer", next_expected.bind_buffer, o_bind_buffer);
            end
        end
    end

    // Watchdog: end the run if no beat moves on either side for too long.
    initial begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Releases with no usable slot id must leave everything untouched.
    task automatic test_invalid_release();
        send_voice_request(make_request(OP_RELEASE, '1, 1'b1, '1, 1'b0, '1));
        send_voice_request(make_request(OP_RELEASE, '0, 1'b0, '0, 1'b0, '0));
    endtask

    // Releasing a free slot reports no stop but still moves it to the oldest end.
    task automatic test_free_slot_release();
        send_voice_request(make_request(OP_RELEASE, 16'h1234, 1'b0, 8'h12, 1'b1, 4'd5));
    endtask

    // Sixteen locked owners take every slot, with extreme handles and buffers.
    task automatic test_fill_high_priority();
        int n;
        for (n = 0; n < NV; n++) begin
            send_voice_request(make_request(OP_ALLOC, HANDLE_W'(n * 4369), 1'b1,
                                            BUFFER_W'(n * 17), 1'b0, SLOT_W'(n)));
        end
    endtask

    // With every slot locked an allocate must fail.
    task automatic test_all_slots_locked();
        send_voice_request(make_request(OP_ALLOC, 16'hBEEF, 1'b0, 8'h3C, 1'b1, 4'd7));
    endtask

    // Free one slot, give it to a low-priority owner, evict that owner, then release the slot again.
    task automatic test_low_priority_eviction();
        send_voice_request(make_request(OP_RELEASE, 16'h0000, 1'b0, 8'h00, 1'b1, 4'd9));
        send_voice_request(make_request(OP_ALLOC, 16'hAAAA, 1'b0, 8'h55, 1'b0, 4'd0));
        send_voice_request(make_request(OP_ALLOC, 16'h5555, 1'b1, 8'hAA, 1'b0, 4'd0));
        send_voice_request(make_request(OP_RELEASE, 16'hFFFF, 1'b1, 8'hFF, 1'b1, 4'd9));
    endtask

    function automatic t_voice_request random_voice_request(input int release_pct,
                                                            input int prio_pct);
        t_voice_request req;
        req.op        = ($urandom_range(99) < release_pct) ? OP_RELEASE : OP_ALLOC;
        req.high_prio = ($urandom_range(99) < prio_pct);
        req.rel_valid = ($urandom_range(99) < 88);
        req.rel_slot  = SLOT_W'($urandom);
        // Handles and buffers lean toward their extremes now and then.
        case ($urandom_range(15))
            0:       req.handle = '0;
            1:       req.handle = '1;
            default: req.handle = HANDLE_W'($urandom);
        endcase
        case ($urandom_range(15))
            0:       req.buffer = '0;
            1:       req.buffer = '1;
            default: req.buffer = BUFFER_W'($urandom);
        endcase
        return req;
    endfunction

    // Random mix in bursts, each burst with its own release and lock bias so that
    // runs reach both a nearly empty pool and a fully locked one.
    task automatic test_random_traffic(input int n_items, input int sender_idle,
                                       input int receiver_idle);
        int n;
        int release_pct;
        int prio_pct;
        send_idle_pct = sender_idle;
        recv_idle_pct = receiver_idle;
        release_pct   = 30;
        prio_pct      = 40;
        for (n = 0; n < n_items; n++) begin
            if (n % 20 == 0) begin
                release_pct = $urandom_range(60, 10);
                prio_pct    = $urandom_range(95, 0);
            end
            send_voice_request(random_voice_request(release_pct, prio_pct));
        end
    endtask

    initial begin
        i_rst_n              = 1'b0;
        i_valid              = 1'b0;
        i_operation          = OP_ALLOC;
        i_owner_handle       = '0;
        i_high_priority      = 1'b0;
        i_buffer_id          = '0;
        i_release_slot_valid = 1'b0;
        i_release_slot       = '0;
        mismatch_count       = 0;
        send_idle_pct        = 20;
        recv_idle_pct        = 79;
        reset_voice_model();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_invalid_release();
        test_free_slot_release();
        test_fill_high_priority();
        test_all_slots_locked();
        test_low_priority_eviction();
        test_random_traffic(PHASE_ITEMS, 20, 79);
        test_random_traffic(PHASE_ITEMS, 79, 20);
        test_random_traffic(PHASE_ITEMS, 0, 0);

        // Drop valid, wait for the last results, then watch for stray beats.
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_voice_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
